// ===== rtl/core/i2c_eeprom_access_sequencer_unit_defines.svh =====
// assertion macros for the eeprom access sequencer
`ifndef I2C_EEPROM_ACCESS_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_EEPROM_ACCESS_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define IEAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IEAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ieas_pkg.sv =====
`default_nettype none

package ieas_pkg;

	localparam logic [7:0] DEV_SEL_RESET      = 8'hA0;
	localparam logic [7:0] RETRY_LIMIT_RESET  = 8'd200;
	localparam logic       WIDE_ADDR_RESET    = 1'b1;
	localparam int         PAGE_BYTES_DEFAULT = 8;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_SELECT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDE_ADDRESS  = 2'd2;

	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_STATUS  = 2'd2;
	localparam logic [1:0] OP_WR_BYTE = 2'd3;

	localparam logic [3:0] ST_START     = 4'd0;
	localparam logic [3:0] ST_REP_START = 4'd1;
	localparam logic [3:0] ST_SLAW_ACK  = 4'd2;
	localparam logic [3:0] ST_SLAW_NACK = 4'd3;
	localparam logic [3:0] ST_TX_ACK    = 4'd4;
	localparam logic [3:0] ST_TX_NACK   = 4'd5;
	localparam logic [3:0] ST_ARB_LOST  = 4'd6;
	localparam logic [3:0] ST_SLAR_ACK  = 4'd7;
	localparam logic [3:0] ST_SLAR_NACK = 4'd8;
	localparam logic [3:0] ST_RX_ACK    = 4'd9;
	localparam logic [3:0] ST_RX_NACK   = 4'd10;

	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_START  = 3'd1;
	localparam logic [2:0] ACT_SEND   = 3'd2;
	localparam logic [2:0] ACT_RXACK  = 3'd3;
	localparam logic [2:0] ACT_RXNACK = 3'd4;
	localparam logic [2:0] ACT_STOP   = 3'd5;

	typedef enum logic [9:0] {
		PH_IDLE   = 10'b00_0000_0001,
		PH_START  = 10'b00_0000_0010,
		PH_SLAW   = 10'b00_0000_0100,
		PH_AHI    = 10'b00_0000_1000,
		PH_ALO    = 10'b00_0001_0000,
		PH_RSTART = 10'b00_0010_0000,
		PH_SLAR   = 10'b00_0100_0000,
		PH_RX     = 10'b00_1000_0000,
		PH_WAITWB = 10'b01_0000_0000,
		PH_TX     = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [2:0]  bus_action;
		logic [7:0]  tx_byte;
		logic        read_valid;
		logic [7:0]  read_byte;
		logic        need_write_byte;
		logic        done_res;
		logic        failed;
		logic [15:0] bytes_done;
		logic        last;
	} res_t;

	function automatic res_t mk_res(
		input logic [2:0]  act,
		input logic [7:0]  tx,
		input logic        rv,
		input logic [7:0]  rb,
		input logic        need,
		input logic        dn,
		input logic        fl,
		input logic [15:0] done
	);
		res_t r;
		r.bus_action      = act;
		r.tx_byte         = tx;
		r.read_valid      = rv;
		r.read_byte       = rb;
		r.need_write_byte = need;
		r.done_res        = dn;
		r.failed          = fl;
		r.bytes_done      = done;
		r.last            = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ieas_channels.sv =====
`default_nettype none

interface ieas_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] mem_address;
	logic [15:0] byte_count;
	logic [3:0]  bus_status;
	logic [7:0]  received_byte;
	logic [7:0]  write_byte;

	modport source (output valid, operation, mem_address, byte_count, bus_status,
		received_byte, write_byte, input ready);
	modport sink (input valid, operation, mem_address, byte_count, bus_status,
		received_byte, write_byte, output ready);
endinterface

interface ieas_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  bus_action;
	logic [7:0]  tx_byte;
	logic        read_valid;
	logic [7:0]  read_byte;
	logic        need_write_byte;
	logic        done_res;
	logic        failed;
	logic [15:0] bytes_done;
	logic        last;

	modport source (output valid, bus_action, tx_byte, read_valid, read_byte,
		need_write_byte, done_res, failed, bytes_done, last, input ready);
	modport sink (input valid, bus_action, tx_byte, read_valid, read_byte,
		need_write_byte, done_res, failed, bytes_done, last, output ready);
endinterface

interface ieas_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/i2c_eeprom_access_sequencer_unit.sv =====
// master-side sequencer for an i2c serial eeprom
// item channel: read/write commands, bus status events and write bytes, one
// transfer per cycle while ready is high; result channel: bus actions,
// received bytes, write byte requests and completion, up to two results per
// item, the final one marked by last; cfg channel: device select, retry limit
// and address width, always ready; the user must see that it is written while
// no command is in flight, which the block itself does not enforce
// an item is registered on acceptance and decoded from the input register;
// its results go into the result buffer, a second one after the first
// throughput: one item per cycle while results drain; the input stage holds
// the reciprocal multiply that splits the start address into page offset
// results queue in a four-entry buffer; an item is decoded only when two
// entries are free, so a stalled receiver drops item.ready once the buffer
// holds three or four results, the next item waiting in the input register
// reset: control and configuration registers return to their defaults, the
// sequencer goes idle and the result buffer empties
`default_nettype none

module i2c_eeprom_access_sequencer_unit #(
	parameter int PAGE_BYTES = ieas_pkg::PAGE_BYTES_DEFAULT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ieas_in_if.sink    item,
	ieas_out_if.source result,
	ieas_cfg_if.sink   cfg
);
	import ieas_pkg::*;

	localparam int OFF_W     = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
	localparam int PAGE_W    = $clog2(PAGE_BYTES + 1);
	localparam int RCP_SHIFT = 24;
	localparam int RCP       = ((1 << RCP_SHIFT) + PAGE_BYTES - 1) / PAGE_BYTES;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W     = $clog2(FIFO_DEPTH);
	localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);

	// configuration
	logic [7:0] dev_sel_q;
	logic [7:0] retry_lim_q;
	logic       wide_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] addr_s1;
	logic [15:0] cnt_s1;
	logic [3:0]  st_s1;
	logic [7:0]  rb_s1;
	logic [7:0]  wb_s1;
	logic [15:0] quot_s1;
	logic [40:0] rcp_prod;

	// sequencer state
	phase_t            phase_q, phase_d;
	logic              is_write_q, is_write_d;
	logic [15:0]       cur_q, cur_d;
	logic [15:0]       rem_q, rem_d;
	logic [PAGE_W-1:0] page_q, page_d;
	logic [OFF_W-1:0]  off_q, off_d;
	logic [15:0]       total_q, total_d;
	logic [7:0]        retry_q, retry_d;

	// result buffer
	res_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic        fire;
	logic        pop;
	logic [1:0]  n_res;
	res_t        res0, res1, head;
	logic [7:0]  sel;
	logic [24:0] qprod;
	logic [24:0] mod_raw;
	logic [24:0] mod_fix;
	logic [PAGE_W-1:0] room_cmd;
	logic [PAGE_W-1:0] room_pg;
	logic [PAGE_W-1:0] page_dec;
	logic [OFF_W-1:0]  off_inc;
	logic [15:0]       rem_dec;

	assign rcp_prod = 41'(item.mem_address) * 41'(RCP);
	assign fire     = valid_s1 && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign pop      = result.valid && result.ready;

	assign item.ready = !valid_s1 || fire;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1   <= item.operation;
			addr_s1 <= item.mem_address;
			cnt_s1  <= item.byte_count;
			st_s1   <= item.bus_status;
			rb_s1   <= item.received_byte;
			wb_s1   <= item.write_byte;
			quot_s1 <= rcp_prod[RCP_SHIFT +: 16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_sel_q   <= DEV_SEL_RESET;
			retry_lim_q <= RETRY_LIMIT_RESET;
			wide_q      <= WIDE_ADDR_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_DEVICE_SELECT: dev_sel_q   <= cfg.data;
				CFG_RETRY_LIMIT:   retry_lim_q <= cfg.data;
				CFG_WIDE_ADDRESS:  wide_q      <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// start address split into page offset
	assign qprod   = 25'(quot_s1) * 25'(PAGE_BYTES);
	assign mod_raw = 25'(addr_s1) - qprod;
	assign mod_fix = (mod_raw >= 25'(PAGE_BYTES)) ? mod_raw - 25'(PAGE_BYTES) : mod_raw;
	assign room_cmd = PAGE_W'(PAGE_BYTES) - PAGE_W'(mod_fix);

	assign rem_dec  = rem_q - 16'd1;
	assign page_dec = page_q - 1'b1;
	assign off_inc  = ((cur_q == 16'hFFFF) || (off_q == OFF_W'(PAGE_BYTES - 1))) ?
		'0 : off_q + 1'b1;
	assign room_pg  = PAGE_W'(PAGE_BYTES) - PAGE_W'(off_inc);

	assign sel = dev_sel_q | (wide_q ? 8'h00 : {4'h0, cur_q[10:8], 1'b0});

	always_comb begin
		phase_d    = phase_q;
		is_write_d = is_write_q;
		cur_d      = cur_q;
		rem_d      = rem_q;
		page_d     = page_q;
		off_d      = off_q;
		total_d    = total_q;
		retry_d    = retry_q;
		res0       = '0;
		res1       = '0;
		n_res      = 2'd0;

		case (op_s1)
			OP_READ, OP_WRITE: begin
				if (phase_q == PH_IDLE) begin
					is_write_d = op_s1[0];
					cur_d      = addr_s1;
					rem_d      = cnt_s1;
					total_d    = '0;
					page_d     = '0;
					off_d      = OFF_W'(mod_fix);
					retry_d    = '0;
					n_res      = 2'd1;
					if (op_s1 == OP_WRITE) begin
						page_d = (cnt_s1 < 16'(room_cmd)) ? PAGE_W'(cnt_s1) : room_cmd;
					end
					if (retry_lim_q == 8'd0) begin
						phase_d = PH_IDLE;
						res0 = mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 16'h0000);
					end else begin
						retry_d = 8'd1;
						phase_d = PH_START;
						res0 = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000);
					end
				end
			end
			OP_STATUS: begin
				case (phase_q)
					PH_START: begin
						n_res = 2'd1;
						if (st_s1 == ST_START || st_s1 == ST_REP_START) begin
							phase_d = PH_SLAW;
							res0 = mk_res(ACT_SEND, sel, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, total_q);
						end else if (st_s1 == ST_ARB_LOST) begin
							res0 = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, total_q);
						end else begin
							phase_d = PH_IDLE;
							res0 = mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, total_q);
						end
					end
					PH_SLAW: begin
						n_res = 2'd1;
						if (st_s1 == ST_SLAW_ACK) begin
							if (wide_q) begin
								phase_d = PH_AHI;
								res0 = mk_res(ACT_SEND, cur_q[15:8], 1'b0, 8'h00, 1'b0, 1'b0,
									1'b0, total_q);
							end else begin
								phase_d = PH_ALO;
								res0 = mk_res(ACT_SEND, cur_q[7:0], 1'b0, 8'h00, 1'b0, 1'b0,
									1'b0, total_q);
							end
						end else if (st_s1 == ST_SLAW_NACK) begin
							// device busy with its internal write
							if (retry_q >= retry_lim_q) begin
								phase_d = PH_IDLE;
								res0 = mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1,
									total_q);
							end else begin
								retry_d = retry_q + 8'd1;
								phase_d = PH_START;
								res0 = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0,
									total_q);
							end
						end else if (st_s1 == ST_ARB_LOST) begin
							phase_d = PH_START;
							res0 = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, total_q);
						end else begin
							phase_d = PH_IDLE;
							res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, total_q);
						end
					end
					PH_AHI, PH_ALO: begin
						n_res = 2'd1;
						if (st_s1 == ST_TX_ACK) begin
							if (phase_q == PH_AHI) begin
								phase_d = PH_ALO;
								res0 = mk_res(ACT_SEND, cur_q[7:0], 1'b0, 8'h00, 1'b0, 1'b0,
									1'b0, total_q);
							end else if (!is_write_q) begin
								phase_d = PH_RSTART;
								res0 = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0,
									total_q);
							end else if (page_q == '0) begin
								phase_d = PH_IDLE;
								res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0,
									total_q);
							end else begin
								phase_d = PH_WAITWB;
								res0 = mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0,
									total_q);
							end
						end else if (st_s1 == ST_TX_NACK) begin
							phase_d = PH_IDLE;
							res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
								is_write_q && (rem_q != 16'd0), total_q);
						end else if (st_s1 == ST_ARB_LOST) begin
							phase_d = PH_START;
							res0 = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, total_q);
						end else begin
							phase_d = PH_IDLE;
							res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, total_q);
						end
					end
					PH_RSTART: begin
						n_res = 2'd1;
						if (st_s1 == ST_START || st_s1 == ST_REP_START) begin
							phase_d = PH_SLAR;
							res0 = mk_res(ACT_SEND, sel | 8'h01, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0,
								total_q);
						end else if (st_s1 == ST_ARB_LOST) begin
							phase_d = PH_START;
							res0 = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, total_q);
						end else begin
							phase_d = PH_IDLE;
							res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, total_q);
						end
					end
					PH_SLAR: begin
						n_res = 2'd1;
						if (st_s1 == ST_SLAR_ACK) begin
							if (rem_q == 16'd0) begin
								phase_d = PH_IDLE;
								res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0,
									total_q);
							end else begin
								phase_d = PH_RX;
								res0 = mk_res((rem_q > 16'd1) ? ACT_RXACK : ACT_RXNACK, 8'h00,
									1'b0, 8'h00, 1'b0, 1'b0, 1'b0, total_q);
							end
						end else if (st_s1 == ST_SLAR_NACK) begin
							phase_d = PH_IDLE;
							res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1,
								is_write_q && (rem_q != 16'd0), total_q);
						end else if (st_s1 == ST_ARB_LOST) begin
							phase_d = PH_START;
							res0 = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, total_q);
						end else begin
							phase_d = PH_IDLE;
							res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, total_q);
						end
					end
					PH_RX: begin
						n_res = 2'd1;
						if (st_s1 == ST_RX_ACK || st_s1 == ST_RX_NACK) begin
							total_d = total_q + 16'd1;
							rem_d   = rem_dec;
							if (st_s1 == ST_RX_NACK || rem_dec == 16'd0) begin
								phase_d = PH_IDLE;
								res0 = mk_res(ACT_STOP, 8'h00, 1'b1, rb_s1, 1'b0, 1'b1, 1'b0,
									total_d);
							end else begin
								res0 = mk_res((rem_dec > 16'd1) ? ACT_RXACK : ACT_RXNACK, 8'h00,
									1'b1, rb_s1, 1'b0, 1'b0, 1'b0, total_d);
							end
						end else begin
							phase_d = PH_IDLE;
							res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, total_q);
						end
					end
					PH_TX: begin
						n_res = 2'd1;
						if (st_s1 == ST_TX_ACK) begin
							total_d = total_q + 16'd1;
							rem_d   = rem_dec;
							cur_d   = cur_q + 16'd1;
							page_d  = page_dec;
							off_d   = off_inc;
							if (page_dec != '0) begin
								phase_d = PH_WAITWB;
								res0 = mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0,
									total_d);
							end else if (rem_dec == 16'd0) begin
								phase_d = PH_IDLE;
								res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0,
									total_d);
							end else begin
								// page boundary: stop, then next page (fails at retry limit 0)
								n_res   = 2'd2;
								res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0,
									total_d);
								page_d  = (rem_dec < 16'(room_pg)) ? PAGE_W'(rem_dec) : room_pg;
								retry_d = '0;
								if (retry_lim_q == 8'd0) begin
									phase_d = PH_IDLE;
									res1 = mk_res(ACT_NONE, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1,
										total_d);
								end else begin
									retry_d = 8'd1;
									phase_d = PH_START;
									res1 = mk_res(ACT_START, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0,
										1'b0, total_d);
								end
							end
						end else begin
							phase_d = PH_IDLE;
							res0 = mk_res(ACT_STOP, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, total_q);
						end
					end
					default: ;
				endcase
			end
			OP_WR_BYTE: begin
				if (phase_q == PH_WAITWB) begin
					n_res   = 2'd1;
					phase_d = PH_TX;
					res0 = mk_res(ACT_SEND, wb_s1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, total_q);
				end
			end
			default: ;
		endcase

		res0.last = (n_res == 2'd1);
		res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			is_write_q <= 1'b0;
			cur_q      <= '0;
			rem_q      <= '0;
			page_q     <= '0;
			off_q      <= '0;
			total_q    <= '0;
			retry_q    <= '0;
		end else if (fire) begin
			phase_q    <= phase_d;
			is_write_q <= is_write_d;
			cur_q      <= cur_d;
			rem_q      <= rem_d;
			page_q     <= page_d;
			off_q      <= off_d;
			total_q    <= total_d;
			retry_q    <= retry_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
			if (n_res == 2'd2) begin
				fifo_q[wr_ptr_q + 1'b1] <= res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (fire ? CNT_W'(n_res) : '0) - CNT_W'(pop);
		end
	end

	assign head = fifo_q[rd_ptr_q];

	assign result.valid           = (count_q != '0);
	assign result.bus_action      = head.bus_action;
	assign result.tx_byte         = head.tx_byte;
	assign result.read_valid      = head.read_valid;
	assign result.read_byte       = head.read_byte;
	assign result.need_write_byte = head.need_write_byte;
	assign result.done_res        = head.done_res;
	assign result.failed          = head.failed;
	assign result.bytes_done      = head.bytes_done;
	assign result.last            = head.last;

endmodule

`default_nettype wire

// ===== rtl/core/ieas_checker.sv =====
`default_nettype none
`include "i2c_eeprom_access_sequencer_unit_defines.svh"

module ieas_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [2:0]  bus_action,
	input wire logic [7:0]  tx_byte,
	input wire logic        read_valid,
	input wire logic        need_write_byte,
	input wire logic        done_res,
	input wire logic        failed,
	input wire logic [15:0] bytes_done,
	input wire logic        last
);
	import ieas_pkg::*;

	`IEAS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`IEAS_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(bus_action) && $stable(tx_byte) && $stable(bytes_done), "result changed while stalled")
	`IEAS_ASSERT_NOW(a_done_last, res_valid && done_res, last, "finish not on the final result")
	`IEAS_ASSERT_NOW(a_need_idle, res_valid && need_write_byte, last && !done_res && (bus_action == ACT_NONE), "write byte request with bus action")
	`IEAS_ASSERT_NOW(a_fail_done, res_valid && failed, done_res && !read_valid, "failure without finish")

endmodule

bind i2c_eeprom_access_sequencer_unit ieas_checker u_ieas_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.bus_action      (result.bus_action),
	.tx_byte         (result.tx_byte),
	.read_valid      (result.read_valid),
	.need_write_byte (result.need_write_byte),
	.done_res        (result.done_res),
	.failed          (result.failed),
	.bytes_done      (result.bytes_done),
	.last            (result.last)
);

`default_nettype wire

// ===== tb/i2c_eeprom_access_sequencer_unit_test.sv =====
`timescale 1ns / 100ps

module i2c_eeprom_access_sequencer_unit_test;
	import ieas_pkg::*;

	localparam int PAGE = PAGE_BYTES_DEFAULT;
	localparam int STALL_LIMIT = 4000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam logic [3:0] ST_OTHER = 4'd11;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] addr;
		logic [15:0] count;
		logic [3:0]  st;
		logic [7:0]  rx;
		logic [7:0]  wb;
	} bus_item_t;

	typedef struct packed {
		phase_t      ph;
		logic        is_wr;
		logic [15:0] addr;
		logic [15:0] rem;
		logic [8:0]  page_left;
		logic [15:0] total;
		logic [7:0]  retries;
		logic [7:0]  dev_sel;
		logic [7:0]  retry_lim;
		logic        wide;
	} seq_state_t;

	logic clk;
	logic arst_n;

	ieas_in_if  item_if ();
	ieas_out_if res_if ();
	ieas_cfg_if cfg_if ();

	i2c_eeprom_access_sequencer_unit #(
		.PAGE_BYTES(PAGE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(res_if),
		.cfg(cfg_if)
	);

	seq_state_t gen_state;
	seq_state_t dut_state;
	bus_item_t  pending[$];
	res_t       expected_res[$];
	int         useful_items;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         fail_count;
	int         stall_cycles;

	function automatic seq_state_t fresh_state();
		seq_state_t s;
		s = '0;
		s.ph = PH_IDLE;
		s.dev_sel = DEV_SEL_RESET;
		s.retry_lim = RETRY_LIMIT_RESET;
		s.wide = WIDE_ADDR_RESET;
		return s;
	endfunction

	function automatic void put(inout seq_state_t s, inout res_t [1:0] r, inout int n,
		input logic [2:0] act, input logic [7:0] tx, input logic need, input logic dn,
		input logic fl);
		if (n < 2) begin
			r[n] = res_t'{act, tx, 1'b0, 8'h00, need, dn, fl, s.total, 1'b0};
			n = n + 1;
		end
	endfunction

	function automatic void finish(inout seq_state_t s, inout res_t [1:0] r, inout int n,
		input logic [2:0] act, input logic fl);
		s.ph = PH_IDLE;
		put(s, r, n, act, 8'h00, 1'b0, 1'b1, fl);
	endfunction

	function automatic void try_start(inout seq_state_t s, inout res_t [1:0] r, inout int n);
		if (s.retries >= s.retry_lim) begin
			finish(s, r, n, ACT_NONE, 1'b1);
		end else begin
			s.retries = s.retries + 8'd1;
			s.ph = PH_START;
			put(s, r, n, ACT_START, 8'h00, 1'b0, 1'b0, 1'b0);
		end
	endfunction

	function automatic void open_page(inout seq_state_t s, inout res_t [1:0] r, inout int n);
		int room;
		room = PAGE - (s.addr % PAGE);
		if (s.rem < room) begin
			s.page_left = 9'(s.rem);
		end else begin
			s.page_left = 9'(room);
		end
		s.retries = '0;
		try_start(s, r, n);
	endfunction

	// advances the sequencer by one item, returns the number of results
	function automatic int seq_step(inout seq_state_t s, input bus_item_t it,
		output res_t [1:0] r);
		int n;
		logic [7:0] sel;
		logic arb_restart;
		n = 0;
		r = '0;
		sel = s.dev_sel | (s.wide ? 8'h00 : {4'h0, s.addr[10:8], 1'b0});
		arb_restart = it.st == ST_ARB_LOST && s.ph != PH_IDLE && s.ph != PH_RX &&
			s.ph != PH_WAITWB && s.ph != PH_TX;
		if (it.op == OP_READ || it.op == OP_WRITE) begin
			if (s.ph == PH_IDLE) begin
				s.is_wr = it.op == OP_WRITE;
				s.addr = it.addr;
				s.rem = it.count;
				s.total = '0;
				s.page_left = '0;
				if (s.is_wr) begin
					open_page(s, r, n);
				end else begin
					s.retries = '0;
					try_start(s, r, n);
				end
			end
		end else if (it.op == OP_WR_BYTE) begin
			if (s.ph == PH_WAITWB) begin
				s.ph = PH_TX;
				put(s, r, n, ACT_SEND, it.wb, 1'b0, 1'b0, 1'b0);
			end
		end else if (arb_restart) begin
			s.ph = PH_START;
			put(s, r, n, ACT_START, 8'h00, 1'b0, 1'b0, 1'b0);
		end else begin
			case (s.ph)
			PH_START: begin
				if (it.st == ST_START || it.st == ST_REP_START) begin
					s.ph = PH_SLAW;
					put(s, r, n, ACT_SEND, sel, 1'b0, 1'b0, 1'b0);
				end else begin
					finish(s, r, n, ACT_NONE, 1'b1);
				end
			end
			PH_SLAW: begin
				if (it.st == ST_SLAW_ACK) begin
					if (s.wide) begin
						s.ph = PH_AHI;
						put(s, r, n, ACT_SEND, s.addr[15:8], 1'b0, 1'b0, 1'b0);
					end else begin
						s.ph = PH_ALO;
						put(s, r, n, ACT_SEND, s.addr[7:0], 1'b0, 1'b0, 1'b0);
					end
				end else if (it.st == ST_SLAW_NACK) begin
					try_start(s, r, n);
				end else begin
					finish(s, r, n, ACT_STOP, 1'b1);
				end
			end
			PH_AHI, PH_ALO: begin
				if (it.st == ST_TX_ACK) begin
					if (s.ph == PH_AHI) begin
						s.ph = PH_ALO;
						put(s, r, n, ACT_SEND, s.addr[7:0], 1'b0, 1'b0, 1'b0);
					end else if (!s.is_wr) begin
						s.ph = PH_RSTART;
						put(s, r, n, ACT_START, 8'h00, 1'b0, 1'b0, 1'b0);
					end else if (s.page_left == 0) begin
						finish(s, r, n, ACT_STOP, 1'b0);
					end else begin
						s.ph = PH_WAITWB;
						put(s, r, n, ACT_NONE, 8'h00, 1'b1, 1'b0, 1'b0);
					end
				end else if (it.st == ST_TX_NACK) begin
					finish(s, r, n, ACT_STOP, s.is_wr && s.rem != 0);
				end else begin
					finish(s, r, n, ACT_STOP, 1'b1);
				end
			end
			PH_RSTART: begin
				if (it.st == ST_START || it.st == ST_REP_START) begin
					s.ph = PH_SLAR;
					put(s, r, n, ACT_SEND, sel | 8'h01, 1'b0, 1'b0, 1'b0);
				end else begin
					finish(s, r, n, ACT_STOP, 1'b1);
				end
			end
			PH_SLAR: begin
				if (it.st == ST_SLAR_ACK) begin
					if (s.rem == 0) begin
						finish(s, r, n, ACT_STOP, 1'b0);
					end else begin
						s.ph = PH_RX;
						put(s, r, n, s.rem > 1 ? ACT_RXACK : ACT_RXNACK, 8'h00, 1'b0, 1'b0,
							1'b0);
					end
				end else if (it.st == ST_SLAR_NACK) begin
					finish(s, r, n, ACT_STOP, s.is_wr && s.rem != 0);
				end else begin
					finish(s, r, n, ACT_STOP, 1'b1);
				end
			end
			PH_RX: begin
				if (it.st == ST_RX_ACK || it.st == ST_RX_NACK) begin
					s.total = s.total + 16'd1;
					s.rem = s.rem - 16'd1;
					if (it.st == ST_RX_NACK || s.rem == 0) begin
						s.ph = PH_IDLE;
						put(s, r, n, ACT_STOP, 8'h00, 1'b0, 1'b1, 1'b0);
					end else begin
						put(s, r, n, s.rem > 1 ? ACT_RXACK : ACT_RXNACK, 8'h00, 1'b0, 1'b0,
							1'b0);
					end
					r[n - 1].read_valid = 1'b1;
					r[n - 1].read_byte = it.rx;
				end else begin
					finish(s, r, n, ACT_STOP, 1'b1);
				end
			end
			PH_TX: begin
				if (it.st == ST_TX_ACK) begin
					s.total = s.total + 16'd1;
					s.rem = s.rem - 16'd1;
					s.addr = s.addr + 16'd1;
					s.page_left = s.page_left - 9'd1;
					if (s.page_left != 0) begin
						s.ph = PH_WAITWB;
						put(s, r, n, ACT_NONE, 8'h00, 1'b1, 1'b0, 1'b0);
					end else if (s.rem == 0) begin
						finish(s, r, n, ACT_STOP, 1'b0);
					end else begin
						// page boundary: stop, then next page (fails at retry limit 0)
						put(s, r, n, ACT_STOP, 8'h00, 1'b0, 1'b0, 1'b0);
						open_page(s, r, n);
					end
				end else begin
					finish(s, r, n, ACT_STOP, 1'b1);
				end
			end
			default: begin
			end
			endcase
		end
		if (n > 0) begin
			r[n - 1].last = 1'b1;
		end
		return n;
	endfunction

	function automatic bus_item_t ev(input logic [3:0] st, input logic [7:0] rx);
		return bus_item_t'{OP_STATUS, 16'h0000, 16'h0000, st, rx, 8'h00};
	endfunction

	// mostly the event that moves the transfer on, sometimes a nack, an
	// arbitration loss or junk
	function automatic bus_item_t pick_item(input seq_state_t s);
		bus_item_t it;
		int roll;
		it = bus_item_t'{2'($urandom), 16'($urandom), 16'($urandom), 4'($urandom),
			8'($urandom), 8'($urandom)};
		roll = $urandom_range(99);
		if (roll < 4) begin
			return it;
		end
		it.op = OP_STATUS;
		case (s.ph)
		PH_IDLE: begin
			it.op = $urandom_range(1) ? OP_WRITE : OP_READ;
			if ($urandom_range(3) == 0) begin
				it.addr[15:3] = '1;
			end
			case ($urandom_range(15))
			0: begin
				it.count = '0;
			end
			1: begin
			end
			default: begin
				it.count = 16'($urandom_range(20, 1));
			end
			endcase
		end
		PH_START, PH_RSTART: begin
			if (roll < 80) begin
				it.st = $urandom_range(1) ? ST_REP_START : ST_START;
			end else if (roll < 90) begin
				it.st = ST_ARB_LOST;
			end
		end
		PH_SLAW: begin
			if (roll < 75) begin
				it.st = ST_SLAW_ACK;
			end else if (roll < 88) begin
				it.st = ST_SLAW_NACK;
			end else if (roll < 94) begin
				it.st = ST_ARB_LOST;
			end
		end
		PH_AHI, PH_ALO: begin
			if (roll < 82) begin
				it.st = ST_TX_ACK;
			end else if (roll < 88) begin
				it.st = ST_TX_NACK;
			end else if (roll < 94) begin
				it.st = ST_ARB_LOST;
			end
		end
		PH_SLAR: begin
			if (roll < 80) begin
				it.st = ST_SLAR_ACK;
			end else if (roll < 88) begin
				it.st = ST_SLAR_NACK;
			end else if (roll < 94) begin
				it.st = ST_ARB_LOST;
			end
		end
		PH_RX: begin
			if (roll < 85) begin
				it.st = ST_RX_ACK;
			end else if (roll < 95) begin
				it.st = ST_RX_NACK;
			end
		end
		PH_WAITWB: begin
			if (roll < 96) begin
				it.op = OP_WR_BYTE;
			end
		end
		PH_TX: begin
			if (roll < 94) begin
				it.st = ST_TX_ACK;
			end
		end
		default: begin
		end
		endcase
		return it;
	endfunction

	function automatic void add_item(input bus_item_t it);
		res_t [1:0] outs;
		if (seq_step(gen_state, it, outs) > 0) begin
			useful_items++;
		end
		pending.push_back(it);
	endfunction

	function automatic string show(input res_t r);
		return $sformatf("act=%0d tx=%02h rv=%b rb=%02h need=%b done=%b fail=%b cnt=%0d last=%b",
			r.bus_action, r.tx_byte, r.read_valid, r.read_byte, r.need_write_byte,
			r.done_res, r.failed, r.bytes_done, r.last);
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= SHOWN_MISMATCHES) begin
			$display("mismatch: %s", msg);
		end
	endfunction

	task automatic wait_drain();
		do @(negedge clk);
		while (pending.size() != 0 || item_if.valid || expected_res.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [7:0] sel, input logic [7:0] lim, input logic wide);
		logic [CFG_IDX_W-1:0] idx [3] = '{CFG_DEVICE_SELECT, CFG_RETRY_LIMIT, CFG_WIDE_ADDRESS};
		logic [7:0] vals [3];
		vals = '{sel, lim, {7'd0, wide}};
		gen_state.dev_sel = sel;
		gen_state.retry_lim = lim;
		gen_state.wide = wide;
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		for (int k = 0; k < 3; k++) begin
			cfg_if.index <= idx[k];
			cfg_if.data <= vals[k];
			do @(posedge clk);
			while (!cfg_if.ready);
		end
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] sel, input logic [7:0] lim, input logic wide,
		input int count, input int send_pct, input int recv_pct);
		bus_item_t it;
		write_regs(sel, lim, wide);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		useful_items = 0;
		while (useful_items < count) begin
			add_item(pick_item(gen_state));
		end
		// bring the sequencer back to idle before the next register update
		while (gen_state.ph != PH_IDLE) begin
			it = '0;
			it.op = gen_state.ph == PH_WAITWB ? OP_WR_BYTE : OP_STATUS;
			it.st = ST_OTHER;
			add_item(it);
		end
		wait_drain();
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.operation = OP_READ;
		item_if.mem_address = '0;
		item_if.byte_count = '0;
		item_if.bus_status = ST_START;
		item_if.received_byte = '0;
		item_if.write_byte = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_DEVICE_SELECT;
		cfg_if.data = '0;
		fail_count = 0;
		stall_cycles = 0;
		useful_items = 0;
		send_idle_pct = 26;
		recv_idle_pct = 68;
		gen_state = fresh_state();
		dut_state = fresh_state();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// stray inputs while idle
		add_item(ev(ST_START, 8'h00));
		add_item(bus_item_t'{OP_WR_BYTE, 16'h0000, 16'h0000, ST_START, 8'h00, 8'hff});
		// two-byte read at the top of the address space
		add_item(bus_item_t'{OP_READ, 16'hffff, 16'd2, ST_START, 8'h00, 8'h00});
		add_item(ev(ST_START, 8'h00));
		add_item(ev(ST_SLAW_ACK, 8'h00));
		add_item(ev(ST_TX_ACK, 8'h00));
		add_item(ev(ST_TX_ACK, 8'h00));
		add_item(bus_item_t'{OP_WRITE, 16'h0000, 16'hffff, ST_START, 8'h00, 8'h00});
		add_item(ev(ST_REP_START, 8'h00));
		add_item(ev(ST_SLAR_ACK, 8'h00));
		add_item(ev(ST_RX_ACK, 8'hff));
		add_item(ev(ST_RX_ACK, 8'h00));
		// write across a page boundary with a busy nack and an arbitration loss
		add_item(bus_item_t'{OP_WRITE, 16'h0006, 16'd3, ST_START, 8'h00, 8'h00});
		add_item(ev(ST_START, 8'h00));
		add_item(ev(ST_SLAW_NACK, 8'h00));
		add_item(ev(ST_ARB_LOST, 8'h00));
		add_item(ev(ST_REP_START, 8'h00));
		add_item(ev(ST_SLAW_ACK, 8'h00));
		add_item(ev(ST_TX_ACK, 8'h00));
		add_item(ev(ST_TX_ACK, 8'h00));
		add_item(ev(ST_TX_ACK, 8'h00));
		add_item(bus_item_t'{OP_WR_BYTE, 16'h0000, 16'h0000, ST_START, 8'h00, 8'hff});
		add_item(ev(ST_TX_ACK, 8'h00));
		add_item(bus_item_t'{OP_WR_BYTE, 16'h0000, 16'h0000, ST_START, 8'h00, 8'h00});
		add_item(ev(ST_TX_ACK, 8'h00));
		// wrong status at the start of the second page
		add_item(ev(ST_SLAW_ACK, 8'h00));
		wait_drain();

		run_phase(8'ha0, 8'd3, 1'b0, 260, 26, 68);
		run_phase(8'h00, 8'hff, 1'b1, 260, 26, 68);
		run_phase(8'hff, 8'd1, 1'b0, 260, 68, 26);
		run_phase(8'h5a, 8'd2, 1'b1, 260, 68, 26);
		run_phase(8'hae, 8'd0, 1'b1, 60, 0, 0);
		run_phase(8'($urandom), 8'd4, 1'b0, 450, 0, 0);

		repeat (20) @(posedge clk);
		if (expected_res.size() != 0) begin
			note_failure($sformatf("%0d expected results never arrived", expected_res.size()));
		end
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			item_if.valid <= 1'b0;
		end else if (!item_if.valid || item_if.ready) begin
			if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_if.valid <= 1'b1;
				item_if.operation <= pending[0].op;
				item_if.mem_address <= pending[0].addr;
				item_if.byte_count <= pending[0].count;
				item_if.bus_status <= pending[0].st;
				item_if.received_byte <= pending[0].rx;
				item_if.write_byte <= pending[0].wb;
				void'(pending.pop_front());
			end else begin
				item_if.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	always @(posedge clk) begin
		res_t [1:0] outs;
		res_t got;
		res_t want;
		int n;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_if.valid && cfg_if.ready) begin
				moved = 1'b1;
				case (cfg_if.index)
				CFG_DEVICE_SELECT: begin
					dut_state.dev_sel = cfg_if.data;
				end
				CFG_RETRY_LIMIT: begin
					dut_state.retry_lim = cfg_if.data;
				end
				CFG_WIDE_ADDRESS: begin
					dut_state.wide = cfg_if.data[0];
				end
				default: begin
				end
				endcase
			end
			if (item_if.valid && item_if.ready) begin
				moved = 1'b1;
				n = seq_step(dut_state, bus_item_t'{item_if.operation, item_if.mem_address,
					item_if.byte_count, item_if.bus_status, item_if.received_byte,
					item_if.write_byte}, outs);
				for (int k = 0; k < n; k++) begin
					expected_res.push_back(outs[k]);
				end
			end
			if (res_if.valid && res_if.ready) begin
				moved = 1'b1;
				got = res_t'{res_if.bus_action, res_if.tx_byte, res_if.read_valid,
					res_if.read_byte, res_if.need_write_byte, res_if.done_res, res_if.failed,
					res_if.bytes_done, res_if.last};
				if (expected_res.size() == 0) begin
					note_failure($sformatf("unexpected result %s", show(got)));
				end else begin
					want = expected_res.pop_front();
					if (got !== want) begin
						note_failure($sformatf("expected %s, got %s", show(want), show(got)));
					end
				end
			end
			if (moved) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule
